FILE: src/ona_pkg.sv
// Shared types, opcodes and bitmap word helpers for the object name allocator.
package ona_pkg;

    localparam int WORD_W  = 16;
    localparam int RES_MAX = 16;

    localparam logic [2:0] OP_GEN    = 3'd0;
    localparam logic [2:0] OP_CLAIM  = 3'd1;
    localparam logic [2:0] OP_QUERY  = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_RESET  = 3'd4;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] req_name;
        logic [4:0] gen_count;
    } t_in;

    typedef struct packed {
        logic [7:0] out_name;
        logic       ok;
        logic       last;
    } t_out;

    typedef struct packed {
        logic       we;
        logic       clr;
        logic [3:0] addr;
        logic       full;
    } t_sum_upd;

    function automatic logic [WORD_W-1:0] f_usable(input logic [3:0] w, input logic [8:0] cap);
        logic [WORD_W-1:0] m;
        logic [7:0]        nm;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            nm   = {w, 4'(b)};
            m[b] = (nm != 8'd0) && ({1'b0, nm} < cap);
        end
        return m;
    endfunction

    function automatic logic [3:0] f_first_zero(input logic [WORD_W-1:0] w);
        logic [3:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!w[b]) begin
                idx = 4'(b);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/ona_ram.sv
// Generic simple dual-port RAM with registered read data.
module ona_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ona_summary.sv
// Per-word valid and full flags with a lowest-non-full-word search.
module ona_summary
    import ona_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_sum_upd         i_upd,
    output logic [DEPTH-1:0] o_wvalid,
    output logic             o_any,
    output logic [AW-1:0]    o_first
);

    logic [DEPTH-1:0] r_wvalid;
    logic [DEPTH-1:0] r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_upd.clr) begin
            r_wvalid <= '0;
            r_full   <= '0;
        end else if (i_upd.we) begin
            r_wvalid[i_upd.addr[AW-1:0]] <= 1'b1;
            r_full[i_upd.addr[AW-1:0]]   <= i_upd.full;
        end
    end

    always_comb begin
        o_any   = 1'b0;
        o_first = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!(r_wvalid[i] && r_full[i])) begin
                o_any   = 1'b1;
                o_first = AW'(i);
            end
        end
    end

    assign o_wvalid = r_wvalid;

endmodule

FILE: src/object_name_allocator.sv
// Object name allocator: used bitmap in RAM words with a full-word summary search.
// Generate: an accept step, then per name a search-and-read and a modify-and-write-back step, or
// only a search step once the table is full. Other requests: an accept step, then a response step.
// Beats leave through an output register; a new item is taken while the last beat waits there.
// i_rst_n clears the word valid flags, so every name reads free with no clearing pass.
// Reset-all clears the same flags when it is accepted.
module object_name_allocator
    import ona_pkg::*;
#(
    parameter int NAMES     = 256,
    parameter int BATCH_MAX = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int CAP   = (NAMES < 256) ? NAMES : 256;
    localparam int DEPTH = (CAP + WORD_W - 1) / WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_I = (BATCH_MAX < RES_MAX) ? BATCH_MAX : RES_MAX;
    localparam logic [8:0] CAP_W = 9'(CAP);
    localparam logic [4:0] LIM   = 5'(LIM_I);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_GMOD = 5'b00100,
        S_NMOD = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_op, n_op;
    logic [7:0]        r_name, n_name;
    logic              r_ok, n_ok;
    logic [4:0]        r_cnt, n_cnt;
    logic [AW-1:0]     r_widx, n_widx;
    logic              r_rd_valid, n_rd_valid;
    logic              r_out_valid;
    t_out              r_out, n_out;
    logic              load;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    t_sum_upd          upd;
    logic [DEPTH-1:0]  wvalid;
    logic              sum_any;
    logic [AW-1:0]     sum_first;

    logic              in_acc, slot_free;
    logic [WORD_W-1:0] rword, usable, new_word, bit_sel;
    logic [3:0]        fz;
    logic [AW-1:0]     req_widx;
    logic              req_ok_name;

    ona_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_widx),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    ona_summary #(.DEPTH(DEPTH), .AW(AW)) u_summary (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_wvalid(wvalid),
        .o_any   (sum_any),
        .o_first (sum_first)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign rword       = r_rd_valid ? ram_rdata : '0;
    assign usable      = f_usable(4'(r_widx), CAP_W);
    assign fz          = f_first_zero(rword | ~usable);
    assign req_widx    = AW'(i_in.req_name[7:4]);
    assign req_ok_name = (i_in.req_name != 8'd0) && ({1'b0, i_in.req_name} < CAP_W);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_name     = r_name;
        n_ok       = r_ok;
        n_cnt      = r_cnt;
        n_widx     = r_widx;
        n_rd_valid = r_rd_valid;
        n_out      = r_out;
        load       = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = req_widx;
        ram_wdata  = rword;
        new_word   = rword;
        bit_sel    = '0;
        upd        = '0;
        upd.addr   = 4'(r_widx);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op   = i_in.opcode;
                    n_name = i_in.req_name;
                    case (i_in.opcode)
                        OP_GEN: begin
                            n_cnt = (i_in.gen_count > LIM) ? LIM : i_in.gen_count;
                            if (n_cnt != 5'd0) begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLAIM, OP_QUERY, OP_DELETE: begin
                            if (req_ok_name) begin
                                ram_re     = 1'b1;
                                n_widx     = req_widx;
                                n_rd_valid = wvalid[req_widx];
                                n_state    = S_NMOD;
                            end else begin
                                n_ok    = 1'b0;
                                n_state = S_RESP;
                            end
                        end
                        OP_RESET: begin
                            upd.clr = 1'b1;
                            n_name  = 8'd0;
                            n_ok    = 1'b1;
                            n_state = S_RESP;
                        end
                        default: begin
                            n_name  = 8'd0;
                            n_ok    = 1'b0;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (sum_any) begin
                    ram_re     = 1'b1;
                    ram_raddr  = sum_first;
                    n_widx     = sum_first;
                    n_rd_valid = wvalid[sum_first];
                    n_state    = S_GMOD;
                end else if (slot_free) begin
                    load       = 1'b1;
                    n_out      = '{out_name: 8'd0, ok: 1'b0, last: (r_cnt == 5'd1)};
                    n_cnt      = r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_GMOD: begin
                bit_sel  = WORD_W'(1) << fz;
                new_word = rword | bit_sel;
                if (slot_free) begin
                    ram_we    = 1'b1;
                    ram_wdata = new_word;
                    upd.we    = 1'b1;
                    upd.full  = &(new_word | ~usable);
                    load      = 1'b1;
                    n_out     = '{out_name: {4'(r_widx), fz}, ok: 1'b1,
                                  last: (r_cnt == 5'd1)};
                    n_cnt     = r_cnt - 5'd1;
                    n_state   = (r_cnt == 5'd1) ? S_IDLE : S_SCAN;
                end
            end
            S_NMOD: begin
                bit_sel = WORD_W'(1) << r_name[3:0];
                case (r_op)
                    OP_CLAIM: begin
                        n_ok     = !rword[r_name[3:0]];
                        new_word = rword | bit_sel;
                    end
                    OP_DELETE: begin
                        n_ok     = rword[r_name[3:0]];
                        new_word = rword & ~bit_sel;
                    end
                    default: begin
                        n_ok     = rword[r_name[3:0]];
                    end
                endcase
                if (slot_free) begin
                    ram_we    = n_ok && (r_op != OP_QUERY);
                    ram_wdata = new_word;
                    upd.we    = ram_we;
                    upd.full  = &(new_word | ~usable);
                    load      = 1'b1;
                    n_out     = '{out_name: r_name, ok: n_ok, last: 1'b1};
                    n_state   = S_IDLE;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_out   = '{out_name: r_name, ok: r_ok, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_name     <= n_name;
        r_ok       <= n_ok;
        r_cnt      <= n_cnt;
        r_widx     <= n_widx;
        r_rd_valid <= n_rd_valid;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: tb/sv/tb_object_name_allocator.sv
// Testbench for the object name allocator: queued request beats, a used-bitmap predictor, beat checks.
module tb_object_name_allocator;
    import ona_pkg::*;

    localparam int NAMES      = 256;
    localparam int BATCH_MAX  = 16;
    localparam int CAP        = NAMES < 256 ? NAMES : 256;
    localparam int LIMIT_TIME = 5_000_000;
    localparam logic [2:0] OP_SPARE_MAX = 3'd7;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_beat   = '0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    t_in  pend_q[$];
    t_out name_expect_q[$];
    bit   used_map[256];
    int   send_idle   = 0;
    int   recv_stall  = 0;
    logic in_took     = 1'b0;
    int   queued      = 0;
    int   taken       = 0;
    int   beats       = 0;
    int   full_misses = 0;
    int   errors      = 0;

    object_name_allocator #(
        .NAMES    (NAMES),
        .BATCH_MAX(BATCH_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out      (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #LIMIT_TIME;
        $display("Timeout with %0d beats still expected", name_expect_q.size());
        $display("FAIL object_name_allocator");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s, got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic bit name_in_range(input logic [7:0] nm);
        return nm != 8'd0 && int'(nm) < CAP;
    endfunction

    function automatic logic [7:0] lowest_free_name();
        for (int i = 1; i < CAP; i++) begin
            if (!used_map[i]) begin
                return 8'(i);
            end
        end
        return 8'd0;
    endfunction

    task automatic predict_names(input t_in b);
        int         n;
        logic [7:0] f;
        t_out       r;
        r = '0;
        case (b.opcode)
            OP_GEN: begin
                n = b.gen_count;
                if (n > BATCH_MAX) n = BATCH_MAX;
                if (n > RES_MAX) n = RES_MAX;
                for (int k = 0; k < n; k++) begin
                    f = lowest_free_name();
                    if (f != 8'd0) begin
                        used_map[f] = 1'b1;
                    end else begin
                        full_misses++;
                    end
                    r.out_name = f;
                    r.ok       = f != 8'd0;
                    r.last     = k == n - 1;
                    name_expect_q.push_back(r);
                end
            end
            OP_CLAIM: begin
                r.out_name = b.req_name;
                r.ok       = name_in_range(b.req_name) && !used_map[b.req_name];
                if (r.ok) used_map[b.req_name] = 1'b1;
            end
            OP_QUERY: begin
                r.out_name = b.req_name;
                r.ok       = name_in_range(b.req_name) && used_map[b.req_name];
            end
            OP_DELETE: begin
                r.out_name = b.req_name;
                r.ok       = name_in_range(b.req_name) && used_map[b.req_name];
                if (r.ok) used_map[b.req_name] = 1'b0;
            end
            OP_RESET: begin
                for (int i = 0; i < 256; i++) used_map[i] = 1'b0;
                r.ok = 1'b1;
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        if (b.opcode != OP_GEN) begin
            r.last = 1'b1;
            name_expect_q.push_back(r);
        end
    endtask

    function automatic t_in make_req(input logic [2:0] op, input logic [7:0] nm,
                                     input logic [4:0] cnt);
        t_in b;
        b.opcode    = op;
        b.req_name  = nm;
        b.gen_count = cnt;
        return b;
    endfunction

    function automatic logic [7:0] pick_name();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 8'($urandom_range(0, 40));
        if (r < 85) return 8'($urandom_range(0, 255));
        if (r < 90) return 8'd0;
        if (r < 95) return 8'(CAP - 1);
        return 8'd1;
    endfunction

    function automatic t_in random_req();
        int         r;
        int         c;
        logic [4:0] cnt;
        r   = $urandom_range(99);
        c   = $urandom_range(99);
        cnt = c < 80 ? 5'($urandom_range(1, 4)) :
              c < 95 ? 5'($urandom_range(5, 16)) : 5'($urandom_range(0, 31));
        if (r < 35) return make_req(OP_GEN, 8'($urandom), cnt);
        if (r < 55) return make_req(OP_CLAIM, pick_name(), 5'($urandom));
        if (r < 75) return make_req(OP_QUERY, pick_name(), 5'($urandom));
        if (r < 90) return make_req(OP_DELETE, pick_name(), 5'($urandom));
        if (r < 95) return make_req(OP_RESET, 8'($urandom), 5'($urandom));
        return make_req(3'($urandom_range(OP_RESET + 1, OP_SPARE_MAX)), 8'($urandom), 5'($urandom));
    endfunction

    task automatic queue_req(input t_in b);
        pend_q.push_back(b);
        queued++;
    endtask

    task automatic queue_table_fill();
        for (int i = 0; i < 16; i++) queue_req(make_req(OP_GEN, 8'($urandom), 5'd16));
        queue_req(make_req(OP_GEN, 8'($urandom), 5'd3));
        queue_req(make_req(OP_CLAIM, 8'd7, 5'($urandom)));
        queue_req(make_req(OP_QUERY, 8'd200, 5'($urandom)));
        queue_req(make_req(OP_DELETE, 8'd100, 5'($urandom)));
        queue_req(make_req(OP_GEN, 8'($urandom), 5'd2));
    endtask

    task automatic queue_directed();
        queue_req(make_req(OP_QUERY, 8'd1, 5'd0));
        queue_req(make_req(OP_GEN, 8'd0, 5'd1));
        queue_req(make_req(OP_GEN, 8'hff, 5'd16));
        queue_req(make_req(OP_GEN, 8'd0, 5'd31));
        queue_req(make_req(OP_GEN, 8'hff, 5'd0));
        queue_req(make_req(OP_CLAIM, 8'd0, 5'd31));
        queue_req(make_req(OP_CLAIM, 8'hff, 5'd0));
        queue_req(make_req(OP_CLAIM, 8'hff, 5'd0));
        queue_req(make_req(OP_QUERY, 8'hff, 5'd0));
        queue_req(make_req(OP_QUERY, 8'd0, 5'd0));
        queue_req(make_req(OP_DELETE, 8'hff, 5'd0));
        queue_req(make_req(OP_DELETE, 8'hff, 5'd0));
        queue_req(make_req(OP_DELETE, 8'd0, 5'd0));
        queue_req(make_req(OP_CLAIM, 8'd5, 5'd0));
        queue_req(make_req(OP_DELETE, 8'd5, 5'd0));
        queue_req(make_req(OP_GEN, 8'd0, 5'd1));
        for (int op = OP_RESET + 1; op <= OP_SPARE_MAX; op++) begin
            queue_req(make_req(3'(op), 8'hff, 5'h1f));
        end
        queue_req(make_req(OP_RESET, 8'hff, 5'h1f));
        queue_req(make_req(OP_QUERY, 8'd1, 5'd0));
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                in_valid <= 1'b1;
                in_beat  <= pend_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= i_rst_n && ($urandom_range(99) < recv_stall);
    end

    always @(posedge i_clk) begin
        t_out want;
        in_took <= i_rst_n && in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                predict_names(in_beat);
                taken <= taken + 1;
            end
            if (o_out_valid && !out_stall) begin
                beats <= beats + 1;
                if (name_expect_q.size() == 0) begin
                    report_mismatch("beat with nothing expected", o_out.out_name, 0);
                end else begin
                    want = name_expect_q.pop_front();
                    if (o_out.out_name !== want.out_name)
                        report_mismatch("out_name", o_out.out_name, want.out_name);
                    if (o_out.ok !== want.ok)
                        report_mismatch("ok", o_out.ok, want.ok);
                    if (o_out.last !== want.last)
                        report_mismatch("last", o_out.last, want.last);
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 48; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 24; recv_stall = 24; end
            endcase
            if (p == 0) queue_directed();
            for (int n = 0; n < 68; n++) begin
                if (n == 30) queue_table_fill();
                else queue_req(random_req());
            end
            while (taken < queued) @(posedge i_clk);
        end
        while (name_expect_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Covered %0d request beats and %0d result beats over four idle/stall mixes;",
                 taken, beats);
        $display("%0d generate results met a full table.", full_misses);
        if (errors == 0) begin
            $display("PASS object_name_allocator");
        end else begin
            $display("FAIL object_name_allocator");
        end
        $finish;
    end

endmodule
